@@ hdl/q2e_pkg.sv @@
package q2e_pkg;

  // datapath widths
  localparam int LW      = 37;  // CORDIC x/y lanes
  localparam int ZW      = 34;  // angle accumulator, 2^-30 rad
  localparam int RW      = 58;  // square-root remainder/root
  localparam int SW      = 30;  // clamped pitch sine, 2^-28
  localparam int NW      = 36;  // atan2 arguments, 2^-28
  localparam int TAB_LEN = 24;
  localparam int SQ_N    = 29;  // root bits of a 57-bit radicand

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [SW-1:0] S_LIMIT     = 30'sd268432772;
  localparam logic [RW-1:0]        ONE_Q56     = 58'd72057594037927936;
  localparam logic signed [16:0]   FULL_LIM    = 17'sd25736;
  localparam logic signed [16:0]   HALF_LIM    = 17'sd12868;
  localparam logic signed [ZW-1:0] ROUND_HALF  = 34'sd65536;

  // one atan2 in flight
  typedef struct packed {
    logic signed [LW-1:0] xv;
    logic signed [LW-1:0] yv;
    logic signed [ZW-1:0] zv;
    logic                 zero;
  } q2e_lane_t;

  // yaw, pitch, roll
  typedef q2e_lane_t [2:0] q2e_lanes_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [RW-1:0] root;
  } q2e_sqrt_t;

  // values riding along the square-root chain
  typedef struct packed {
    logic signed [SW-1:0] s;
    logic signed [NW-1:0] yaw_n;
    logic signed [NW-1:0] yaw_d;
    logic signed [NW-1:0] rol_n;
    logic signed [NW-1:0] rol_d;
  } q2e_side_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = 34'sd843314856;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043836;
      3:  r = 34'sd133525158;
      4:  r = 34'sd67021686;
      5:  r = 34'sd33543515;
      6:  r = 34'sd16775850;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194282;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      23: r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

  // quadrant fold so the vectoring loop starts with x >= 0
  function automatic q2e_lane_t prerot(input logic signed [LW-1:0] n,
                                       input logic signed [LW-1:0] d);
    q2e_lane_t l;
    l.xv   = d;
    l.yv   = n;
    l.zv   = '0;
    l.zero = (n == '0) && (d == '0);
    if (d < 0) begin
      if (n >= 0) begin
        l.xv = n;
        l.yv = -d;
        l.zv = HALF_PI_Q30;
      end else begin
        l.xv = -n;
        l.yv = d;
        l.zv = -HALF_PI_Q30;
      end
    end
    return l;
  endfunction

  // round 2^-30 rad to Q3.13 and clamp
  function automatic logic signed [16:0] to_q13(input q2e_lane_t l,
                                                input logic signed [16:0] lim);
    logic signed [ZW-1:0] t;
    logic signed [16:0]   r;
    t = (l.zv + ROUND_HALF) >>> 17;
    r = t[16:0];
    if (l.zero) r = '0;
    else if (r > lim) r = lim;
    else if (r < -lim) r = -lim;
    return r;
  endfunction

endpackage

@@ hdl/quaternion_to_zyx_euler.sv @@
// Quaternion to ZYX Euler angles.
// Input channel: quat_w/x/y/z_i in signed Q1.14, handshake in_valid_i /
// in_stall_o; an item is taken on a clock edge with valid high, stall low.
// Output channel: yaw/roll in signed Q3.13 and pitch in signed Q2.13
// radians, handshake out_valid_o / out_stall_i, same rule.
// Yaw and roll are atan2 by vectoring CORDIC; pitch is asin of the clamped
// sine, taken as atan2(s, sqrt(1 - s^2)).
// Pipeline from acceptance to out_valid_o: four arithmetic stages, a
// 29-cell square-root chain (one root bit per cell), a quadrant fold, one
// CORDIC cell per step and the output rounding register.
// Throughput: one item per cycle unless stalled; each stage is a register.
// Each stage holds its item only while the next is full and stalled, so a
// stall on the output fills the pipeline bubble by bubble before
// in_stall_o rises; nothing is dropped. No state is kept between items.
// Reset clears all stage valid bits; the block accepts items right after.
module quaternion_to_zyx_euler #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] yaw_angle_o,
  output logic signed [14:0] pitch_angle_o,
  output logic signed [15:0] roll_angle_o
);
  import q2e_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;

  // product stage
  logic p_v_q, p_rdy;
  logic signed [31:0] ww_q, xx_q, yy_q, zz_q, xy_q, wz_q, yz_q, wx_q, wy_q, xz_q;
  // sum stage
  logic s_v_q, s_rdy;
  q2e_side_t s_side_q;
  logic signed [SW-1:0] s_clip;
  logic signed [NW-1:0] s_raw;
  // square stage
  logic q_v_q, q_rdy;
  q2e_side_t q_side_q;
  logic [RW-1:0] s2_q;
  logic signed [2*SW-1:0] s2_full;
  // radicand stage
  logic r_v_q, r_rdy;
  q2e_side_t r_side_q;
  q2e_sqrt_t r_sq_q;
  // square-root chain
  logic      sq_v   [0:SQ_N];
  logic      sq_rdy [0:SQ_N];
  q2e_sqrt_t sq_dat [0:SQ_N];
  q2e_side_t sq_side[0:SQ_N];
  // fold stage
  logic e_v_q, e_rdy;
  q2e_lanes_t e_lanes_q;
  logic signed [LW-1:0] c_ext;
  // CORDIC chain
  logic       cd_v   [0:NSTEP];
  logic       cd_rdy [0:NSTEP];
  q2e_lanes_t cd_dat [0:NSTEP];
  // output stage
  logic o_v_q, o_rdy;
  logic signed [15:0] yaw_q, roll_q;
  logic signed [14:0] pit_q;
  logic signed [16:0] yaw_c, pit_c, roll_c;

  // backpressure: a stage takes new data when empty or moving on
  assign o_rdy  = !o_v_q || !out_stall_i;
  assign e_rdy  = !e_v_q || cd_rdy[0];
  assign r_rdy  = !r_v_q || sq_rdy[0];
  assign q_rdy  = !q_v_q || r_rdy;
  assign s_rdy  = !s_v_q || q_rdy;
  assign p_rdy  = !p_v_q || s_rdy;
  assign in_stall_o = !p_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
      s_v_q <= 1'b0;
      q_v_q <= 1'b0;
      r_v_q <= 1'b0;
      e_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (p_rdy) p_v_q <= in_valid_i;
      if (s_rdy) s_v_q <= p_v_q;
      if (q_rdy) q_v_q <= s_v_q;
      if (r_rdy) r_v_q <= q_v_q;
      if (e_rdy) e_v_q <= sq_v[SQ_N];
      if (o_rdy) o_v_q <= cd_v[NSTEP];
    end
  end

  // products
  always_ff @(posedge clk_i) begin
    if (p_rdy && in_valid_i) begin
      ww_q <= quat_w_i * quat_w_i;
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
      xy_q <= quat_x_i * quat_y_i;
      wz_q <= quat_w_i * quat_z_i;
      yz_q <= quat_y_i * quat_z_i;
      wx_q <= quat_w_i * quat_x_i;
      wy_q <= quat_w_i * quat_y_i;
      xz_q <= quat_x_i * quat_z_i;
    end
  end

  // pitch sine, saturated
  always_comb begin
    s_raw = (NW'(wy_q) - NW'(xz_q)) <<< 1;
    if (s_raw > NW'(S_LIMIT)) s_clip = S_LIMIT;
    else if (s_raw < -NW'(S_LIMIT)) s_clip = -S_LIMIT;
    else s_clip = s_raw[SW-1:0];
  end

  // sums
  always_ff @(posedge clk_i) begin
    if (s_rdy && p_v_q) begin
      s_side_q.s     <= s_clip;
      s_side_q.yaw_n <= (NW'(xy_q) + NW'(wz_q)) <<< 1;
      s_side_q.yaw_d <= NW'(ww_q) + NW'(xx_q) - NW'(yy_q) - NW'(zz_q);
      s_side_q.rol_n <= (NW'(yz_q) + NW'(wx_q)) <<< 1;
      s_side_q.rol_d <= NW'(ww_q) - NW'(xx_q) - NW'(yy_q) + NW'(zz_q);
    end
  end

  // square of the sine
  assign s2_full = s_side_q.s * s_side_q.s;

  always_ff @(posedge clk_i) begin
    if (q_rdy && s_v_q) begin
      s2_q     <= s2_full[RW-1:0];
      q_side_q <= s_side_q;
    end
  end

  // radicand 1 - s^2
  always_ff @(posedge clk_i) begin
    if (r_rdy && q_v_q) begin
      r_sq_q.rem  <= ONE_Q56 - s2_q;
      r_sq_q.root <= '0;
      r_side_q    <= q_side_q;
    end
  end

  assign sq_v[0]    = r_v_q;
  assign sq_dat[0]  = r_sq_q;
  assign sq_side[0] = r_side_q;
  assign sq_rdy[SQ_N] = e_rdy;

  // one root bit per cell, most significant first
  for (genvar g = 0; g < SQ_N; g++) begin : g_sqrt
    q2e_sqrt_cell #(.K(SQ_N - 1 - g)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (sq_v[g]),
      .in_ready_o (sq_rdy[g]),
      .in_sq_i    (sq_dat[g]),
      .in_side_i  (sq_side[g]),
      .out_valid_o(sq_v[g+1]),
      .out_ready_i(sq_rdy[g+1]),
      .out_sq_o   (sq_dat[g+1]),
      .out_side_o (sq_side[g+1])
    );
  end

  assign c_ext = LW'(sq_dat[SQ_N].root[SQ_N-1:0]);

  // quadrant fold of all three lanes
  always_ff @(posedge clk_i) begin
    if (e_rdy && sq_v[SQ_N]) begin
      e_lanes_q[0] <= prerot(LW'(sq_side[SQ_N].yaw_n), LW'(sq_side[SQ_N].yaw_d));
      e_lanes_q[1] <= prerot(LW'(sq_side[SQ_N].s), c_ext);
      e_lanes_q[2] <= prerot(LW'(sq_side[SQ_N].rol_n), LW'(sq_side[SQ_N].rol_d));
    end
  end

  assign cd_v[0]   = e_v_q;
  assign cd_dat[0] = e_lanes_q;
  assign cd_rdy[NSTEP] = o_rdy;

  for (genvar g = 0; g < NSTEP; g++) begin : g_cordic
    q2e_cordic_cell #(.SHIFT(g)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (cd_v[g]),
      .in_ready_o (cd_rdy[g]),
      .in_lanes_i (cd_dat[g]),
      .out_valid_o(cd_v[g+1]),
      .out_ready_i(cd_rdy[g+1]),
      .out_lanes_o(cd_dat[g+1])
    );
  end

  // rounding to Q3.13 yaw/roll and Q2.13 pitch
  assign yaw_c  = to_q13(cd_dat[NSTEP][0], FULL_LIM);
  assign pit_c  = to_q13(cd_dat[NSTEP][1], HALF_LIM);
  assign roll_c = to_q13(cd_dat[NSTEP][2], FULL_LIM);

  always_ff @(posedge clk_i) begin
    if (o_rdy && cd_v[NSTEP]) begin
      yaw_q  <= yaw_c[15:0];
      pit_q  <= pit_c[14:0];
      roll_q <= roll_c[15:0];
    end
  end

  assign out_valid_o   = o_v_q;
  assign yaw_angle_o   = yaw_q;
  assign pitch_angle_o = pit_q;
  assign roll_angle_o  = roll_q;

endmodule

@@ hdl/q2e_sqrt_cell.sv @@
module q2e_sqrt_cell #(
  parameter int K = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  q2e_pkg::q2e_sqrt_t   in_sq_i,
  input  q2e_pkg::q2e_side_t   in_side_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output q2e_pkg::q2e_sqrt_t   out_sq_o,
  output q2e_pkg::q2e_side_t   out_side_o
);
  import q2e_pkg::*;

  localparam logic [RW-1:0] BIT = RW'(1) << (2 * K);

  logic       valid_q;
  q2e_sqrt_t  sq_d, sq_q;
  q2e_side_t  side_q;
  logic [RW-1:0] trial;

  assign in_ready_o = !valid_q || out_ready_i;

  // one restoring root step
  always_comb begin
    trial = in_sq_i.root + BIT;
    if (in_sq_i.rem >= trial) begin
      sq_d.rem  = in_sq_i.rem - trial;
      sq_d.root = (in_sq_i.root >> 1) + BIT;
    end else begin
      sq_d.rem  = in_sq_i.rem;
      sq_d.root = in_sq_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      sq_q   <= sq_d;
      side_q <= in_side_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_sq_o    = sq_q;
  assign out_side_o  = side_q;

endmodule

@@ hdl/q2e_cordic_cell.sv @@
module q2e_cordic_cell #(
  parameter int SHIFT = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  q2e_pkg::q2e_lanes_t  in_lanes_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output q2e_pkg::q2e_lanes_t  out_lanes_o
);
  import q2e_pkg::*;

  localparam logic signed [ZW-1:0] ANG = atan_q30(SHIFT);

  logic       valid_q;
  q2e_lanes_t lanes_d, lanes_q;

  assign in_ready_o = !valid_q || out_ready_i;

  // one vectoring micro-rotation on each lane
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lanes_d[k] = in_lanes_i[k];
      if (in_lanes_i[k].yv > 0) begin
        lanes_d[k].xv = in_lanes_i[k].xv + (in_lanes_i[k].yv >>> SHIFT);
        lanes_d[k].yv = in_lanes_i[k].yv - (in_lanes_i[k].xv >>> SHIFT);
        lanes_d[k].zv = in_lanes_i[k].zv + ANG;
      end else begin
        lanes_d[k].xv = in_lanes_i[k].xv - (in_lanes_i[k].yv >>> SHIFT);
        lanes_d[k].yv = in_lanes_i[k].yv + (in_lanes_i[k].xv >>> SHIFT);
        lanes_d[k].zv = in_lanes_i[k].zv - ANG;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      lanes_q <= lanes_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_lanes_o = lanes_q;

endmodule
